@@ sv/vlmc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlmc_pkg
// Shared types and constants of the vent and light mode controller.
// ----------------------------------------------------------------------------
package vlmc_pkg;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 12;
    localparam int FIELD_W     = 12;

    localparam logic [1:0] MODE_AUTO   = 2'd0;
    localparam logic [1:0] MODE_MANUAL = 2'd1;
    localparam logic [1:0] MODE_SAFETY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_TEMP_OPEN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_CLOSE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_THRESH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BEEP_HALF    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OPEN_ANGLE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CLOSED_ANGLE = 3'd6;

    localparam logic signed [FIELD_W-1:0] HUM_MIN_TENTHS  = 12'sd0;
    localparam logic signed [FIELD_W-1:0] HUM_MAX_TENTHS  = 12'sd1000;
    localparam logic signed [FIELD_W-1:0] TEMP_MIN_TENTHS = -12'sd400;
    localparam logic signed [FIELD_W-1:0] TEMP_MAX_TENTHS = 12'sd800;

    typedef struct packed {
        logic signed [10:0] temp_open_tenths;
        logic signed [10:0] temp_close_tenths;
        logic [11:0]        lux_limit;
        logic [11:0]        debounce_ticks;
        logic [11:0]        beep_half_ticks;
        logic [7:0]         angle_open;
        logic [7:0]         angle_shut;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        temp_open_tenths:  11'sd300,
        temp_close_tenths: 11'sd280,
        lux_limit:         12'd700,
        debounce_ticks:    12'd200,
        beep_half_ticks:   12'd500,
        angle_open:        8'd90,
        angle_shut:        8'd0
    };

    typedef struct packed {
        logic [FIELD_W-1:0]        light_reading;
        logic signed [FIELD_W-1:0] humidity_tenths;
        logic signed [FIELD_W-1:0] temp_tenths;
        logic                      read_failed;
        logic                      sample_valid;
        logic                      button_level;
    } t_item;

    typedef struct packed {
        logic       sensor_fault;
        logic       buzzer_on;
        logic       supplemental_on;
        logic [7:0] vent_angle;
        logic       vent_is_opened;
        logic [1:0] mode;
    } t_result;

    typedef struct packed {
        logic [1:0] mode;
        logic       vent;
        logic       light;
        logic       button_prev;
        logic       beep_phase;
        logic       fault;
    } t_ctl;

    localparam t_ctl CTL_RESET = '{
        mode:        MODE_AUTO,
        vent:        1'b0,
        light:       1'b0,
        button_prev: 1'b1,
        beep_phase:  1'b0,
        fault:       1'b0
    };

endpackage

@@ sv/vlmc_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlmc_step
// Next-state and result logic for one tick: button, sample, mode and buzzer.
// ----------------------------------------------------------------------------
module vlmc_step import vlmc_pkg::*; #(
    parameter int READING_BITS = 12,
    parameter int AGE_BITS     = 12
) (
    input  t_cfg                           i_cfg,
    input  t_item                          i_item,
    input  t_ctl                           i_ctl,
    input  logic signed [READING_BITS-1:0] i_temp,
    input  logic [READING_BITS-1:0]        i_lum,
    input  logic [AGE_BITS-1:0]            i_press_age,
    input  logic [AGE_BITS-1:0]            i_beep_age,
    output t_ctl                           o_ctl,
    output logic signed [READING_BITS-1:0] o_temp,
    output logic [READING_BITS-1:0]        o_lum,
    output logic [AGE_BITS-1:0]            o_press_age,
    output logic [AGE_BITS-1:0]            o_beep_age,
    output t_result                        o_result
);

    localparam int TW = ((READING_BITS > 11) ? READING_BITS : 11) + 1;
    localparam int LW = (READING_BITS > 12) ? READING_BITS : 12;
    localparam int AW = (AGE_BITS > 12) ? AGE_BITS : 12;

    logic [AGE_BITS-1:0] w_press_inc;
    logic [AGE_BITS-1:0] w_beep_inc;
    logic                w_press;
    logic                w_bad;
    logic                w_light_want;
    logic signed [TW-1:0] w_temp_cmp;

    assign w_press_inc = (i_press_age == {AGE_BITS{1'b1}}) ? i_press_age
                                                           : i_press_age + 1'b1;
    assign w_beep_inc  = (i_beep_age == {AGE_BITS{1'b1}}) ? i_beep_age
                                                          : i_beep_age + 1'b1;
    assign w_press = !i_item.button_level && i_ctl.button_prev &&
                     (AW'(w_press_inc) >= AW'(i_cfg.debounce_ticks));
    assign w_bad = i_item.read_failed ||
                   (i_item.humidity_tenths < HUM_MIN_TENTHS) ||
                   (i_item.humidity_tenths > HUM_MAX_TENTHS) ||
                   (i_item.temp_tenths < TEMP_MIN_TENTHS) ||
                   (i_item.temp_tenths > TEMP_MAX_TENTHS);

    always_comb begin
        o_ctl       = i_ctl;
        o_temp      = i_temp;
        o_lum       = i_lum;
        o_press_age = w_press_inc;
        o_beep_age  = w_beep_inc;

        if (w_press) begin
            o_press_age = '0;
            case (i_ctl.mode)
                MODE_SAFETY: o_ctl.vent = 1'b1;
                MODE_MANUAL: o_ctl.mode = MODE_AUTO;
                default: begin
                    o_ctl.mode = MODE_MANUAL;
                    o_ctl.vent = 1'b1;
                end
            endcase
        end
        o_ctl.button_prev = i_item.button_level;

        if (i_item.sample_valid) begin
            if (w_bad) begin
                o_ctl.fault = 1'b1;
                o_ctl.mode  = MODE_SAFETY;
            end else begin
                o_temp      = READING_BITS'(i_item.temp_tenths);
                o_lum       = READING_BITS'(i_item.light_reading);
                o_ctl.fault = 1'b0;
                if (o_ctl.mode == MODE_SAFETY) begin
                    o_ctl.mode = MODE_AUTO;
                end
            end
        end

        w_light_want = LW'(o_lum) > LW'(i_cfg.lux_limit);
        w_temp_cmp   = TW'(o_temp);
        case (o_ctl.mode)
            MODE_SAFETY: begin
                o_ctl.vent  = 1'b1;
                o_ctl.light = 1'b0;
            end
            MODE_MANUAL: begin
                o_ctl.vent  = 1'b1;
                o_ctl.light = w_light_want;
            end
            default: begin
                if (w_temp_cmp >= TW'(i_cfg.temp_open_tenths)) begin
                    o_ctl.vent = 1'b1;
                end else if (w_temp_cmp <= TW'(i_cfg.temp_close_tenths)) begin
                    o_ctl.vent = 1'b0;
                end
                o_ctl.light = w_light_want;
            end
        endcase

        if (o_ctl.mode == MODE_SAFETY) begin
            if (AW'(w_beep_inc) >= AW'(i_cfg.beep_half_ticks)) begin
                o_beep_age       = '0;
                o_ctl.beep_phase = !i_ctl.beep_phase;
            end
        end else begin
            o_ctl.beep_phase = 1'b0;
        end

        o_result.mode            = o_ctl.mode;
        o_result.vent_is_opened  = o_ctl.vent;
        o_result.vent_angle      = o_ctl.vent ? i_cfg.angle_open
                                              : i_cfg.angle_shut;
        o_result.supplemental_on = o_ctl.light;
        o_result.buzzer_on       = o_ctl.beep_phase;
        o_result.sensor_fault    = o_ctl.fault;
    end

endmodule

@@ sv/vent_light_mode_controller_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vent_light_mode_controller_core
// Tick-driven vent, lighting and buzzer mode controller with stream ports.
// ----------------------------------------------------------------------------
// The block takes one tick transaction per clock cycle while the result side
// is not stalled, and returns one result transaction for each: the tick is
// captured in an input register, and the whole state update for that tick
// is done combinationally into the state and result registers. The rate of
// one tick per cycle rests on that update of the controller state being done
// at once. Both stages advance independently, so a stalled result does not
// stop a new tick from being captured while the input register is free.
module vent_light_mode_controller_core import vlmc_pkg::*; #(
    parameter int READING_BITS = 12,
    parameter int AGE_BITS     = 12
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // Fields from bit 0: button_level, sample_valid, read_failed, temp_tenths,
    // humidity_tenths, light_reading, one zero pad bit.
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // Fields from bit 0: mode, vent_is_opened, vent_angle, supplemental_on,
    // buzzer_on, sensor_fault, two zero pad bits.
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    t_cfg                           r_cfg;
    t_item                          r_in_item;
    logic                           r_in_valid;
    t_result                        r_out;
    logic                           r_out_valid;
    t_ctl                           r_ctl;
    logic signed [READING_BITS-1:0] r_temp;
    logic [READING_BITS-1:0]        r_lum;
    logic [AGE_BITS-1:0]            r_press_age;
    logic [AGE_BITS-1:0]            r_beep_age;

    t_ctl                           n_ctl;
    logic signed [READING_BITS-1:0] n_temp;
    logic [READING_BITS-1:0]        n_lum;
    logic [AGE_BITS-1:0]            n_press_age;
    logic [AGE_BITS-1:0]            n_beep_age;
    t_result                        n_out;

    logic w_out_adv;
    logic w_fire;

    assign w_out_adv     = !r_out_valid || m_axis_tready;
    assign w_fire        = r_in_valid && w_out_adv;
    assign s_axis_tready = !r_in_valid || w_out_adv;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W - $bits(t_result)){1'b0}}, r_out};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_TEMP_OPEN:    r_cfg.temp_open_tenths  <= i_cfg_wdata[10:0];
                REG_TEMP_CLOSE:   r_cfg.temp_close_tenths <= i_cfg_wdata[10:0];
                REG_LIGHT_THRESH: r_cfg.lux_limit         <= i_cfg_wdata;
                REG_DEBOUNCE:     r_cfg.debounce_ticks    <= i_cfg_wdata;
                REG_BEEP_HALF:    r_cfg.beep_half_ticks   <= i_cfg_wdata;
                REG_OPEN_ANGLE:   r_cfg.angle_open        <= i_cfg_wdata[7:0];
                REG_CLOSED_ANGLE: r_cfg.angle_shut        <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_item <= s_axis_tdata[$bits(t_item)-1:0];
        end
    end

    vlmc_step #(
        .READING_BITS(READING_BITS),
        .AGE_BITS    (AGE_BITS)
    ) u_step (
        .i_cfg      (r_cfg),
        .i_item     (r_in_item),
        .i_ctl      (r_ctl),
        .i_temp     (r_temp),
        .i_lum      (r_lum),
        .i_press_age(r_press_age),
        .i_beep_age (r_beep_age),
        .o_ctl      (n_ctl),
        .o_temp     (n_temp),
        .o_lum      (n_lum),
        .o_press_age(n_press_age),
        .o_beep_age (n_beep_age),
        .o_result   (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_ctl       <= CTL_RESET;
            r_temp      <= '0;
            r_lum       <= '0;
            r_press_age <= '0;
            r_beep_age  <= '0;
        end else begin
            if (w_out_adv) begin
                r_out_valid <= r_in_valid;
            end
            if (w_fire) begin
                r_ctl       <= n_ctl;
                r_temp      <= n_temp;
                r_lum       <= n_lum;
                r_press_age <= n_press_age;
                r_beep_age  <= n_beep_age;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= n_out;
        end
    end

    a_safety_vent_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.mode == MODE_SAFETY) |-> r_out.vent_is_opened)
        else $error("safety result with vent closed");

    a_safety_light_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.mode == MODE_SAFETY) |-> !r_out.supplemental_on)
        else $error("safety result with supplemental light on");

    a_buzzer_safety: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.buzzer_on) |-> (r_out.mode == MODE_SAFETY))
        else $error("buzzer on outside safety mode");

    a_manual_vent_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ctl.mode == MODE_MANUAL) |-> r_ctl.vent)
        else $error("manual mode with vent closed");

    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> s_axis_tready)
        else $error("input stalled while result register is empty");

endmodule

@@ tb/tb_vent_light_mode_controller_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vent_light_mode_controller_core
// Self-checking testbench of the vent and light mode controller.
// ----------------------------------------------------------------------------
// A short table of ticks covers the reset state, the limits of valid samples,
// failed reads, the zero buzzer half period and button presses in safety, auto
// and manual mode. Random ticks then follow under several register settings,
// both extremes among them. Every result transaction is compared field by
// field with the typed table values or a tick-level model kept in this file.
// Both stream sides idle at random, and the result side holds off once for a
// long stretch so that the block backs up into its tick input.
// ----------------------------------------------------------------------------
module tb_vent_light_mode_controller_core;
    import vlmc_pkg::*;

    localparam int CLK_HALF_NS     = 5;
    localparam int RESET_CYCLES    = 5;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int PHASE_TICKS     = 75;
    localparam int RANDOM_PHASES   = 5;
    localparam int LOW_PHASE       = 1;
    localparam int HIGH_PHASE      = 2;
    localparam int CALM_PHASE      = 3;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 8;
    localparam int REPORT_MAX      = 10;
    localparam int NUM_STEPS       = 25;
    localparam int PHASE_B_FIRST   = 16;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam logic [FIELD_W-1:0]   AGE_SAT    = '1;

    localparam t_cfg TABLE_CFG = '{
        temp_open_tenths:  11'sd0,
        temp_close_tenths: 11'h7FF,
        lux_limit:         12'd0,
        debounce_ticks:    12'd0,
        beep_half_ticks:   12'd0,
        angle_open:        8'd255,
        angle_shut:        8'd180
    };

    typedef struct packed {
        logic                      button;
        logic                      sample;
        logic                      bad_read;
        logic signed [FIELD_W-1:0] temp;
        logic signed [FIELD_W-1:0] hum;
        logic [FIELD_W-1:0]        lux;
        logic                      typed;
        logic [1:0]                mode;
        logic                      vent;
        logic [7:0]                angle;
        logic                      lamp;
        logic                      buzz;
        logic                      fault;
    } t_tick_row;

    localparam t_tick_row STEPS [NUM_STEPS] = '{
        '{1'b1, 1'b0, 1'b0, 12'sd0, 12'sd0, 12'd0,
          1'b1, MODE_AUTO, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 1'b0, 1'b0, 12'sd0, 12'sd0, 12'd0,
          1'b1, MODE_AUTO, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0},
        '{1'b1, 1'b1, 1'b0, 12'sd800, 12'sd1000, 12'd4095,
          1'b1, MODE_AUTO, 1'b1, 8'd90, 1'b1, 1'b0, 1'b0},
        '{1'b1, 1'b1, 1'b1, 12'sd0, 12'sd500, 12'd0,
          1'b1, MODE_SAFETY, 1'b1, 8'd90, 1'b0, 1'b0, 1'b1},
        '{1'b1, 1'b1, 1'b0, -12'sd400, 12'sd0, 12'd0,
          1'b1, MODE_AUTO, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0},
        '{1'b1, 1'b1, 1'b0, 12'sd801, 12'sd500, 12'd0,
          1'b1, MODE_SAFETY, 1'b1, 8'd90, 1'b0, 1'b0, 1'b1},
        '{1'b1, 1'b1, 1'b0, 12'sd300, 12'sd500, 12'd701,
          1'b1, MODE_AUTO, 1'b1, 8'd90, 1'b1, 1'b0, 1'b0},
        '{1'b1, 1'b1, 1'b0, -12'sd401, 12'sd500, 12'd0,
          1'b1, MODE_SAFETY, 1'b1, 8'd90, 1'b0, 1'b0, 1'b1},
        '{1'b1, 1'b1, 1'b0, 12'sd290, 12'sd500, 12'd700,
          1'b0, MODE_AUTO, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0},
        '{1'b1, 1'b1, 1'b0, 12'sd280, 12'sd1000, 12'd0,
          1'b0, MODE_AUTO, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0},
        '{1'b1, 1'b1, 1'b0, 12'sd0, -12'sd1, 12'd0,
          1'b1, MODE_SAFETY, 1'b1, 8'd90, 1'b0, 1'b0, 1'b1},
        '{1'b1, 1'b1, 1'b0, 12'sd0, 12'sd1001, 12'd0,
          1'b1, MODE_SAFETY, 1'b1, 8'd90, 1'b0, 1'b0, 1'b1},
        '{1'b1, 1'b1, 1'b0, 12'h800, 12'sd2047, 12'd4095,
          1'b1, MODE_SAFETY, 1'b1, 8'd90, 1'b0, 1'b0, 1'b1},
        '{1'b1, 1'b1, 1'b0, 12'sd2047, 12'h800, 12'd0,
          1'b1, MODE_SAFETY, 1'b1, 8'd90, 1'b0, 1'b0, 1'b1},
        '{1'b1, 1'b0, 1'b1, 12'sd1500, -12'sd500, 12'd4095,
          1'b1, MODE_SAFETY, 1'b1, 8'd90, 1'b0, 1'b0, 1'b1},
        '{1'b0, 1'b0, 1'b0, 12'sd0, 12'sd0, 12'd0,
          1'b0, MODE_AUTO, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0},
        '{1'b1, 1'b0, 1'b0, 12'sd0, 12'sd0, 12'd0,
          1'b0, MODE_AUTO, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 1'b0, 1'b0, 12'sd0, 12'sd0, 12'd0,
          1'b0, MODE_AUTO, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0},
        '{1'b1, 1'b0, 1'b0, 12'sd0, 12'sd0, 12'd0,
          1'b0, MODE_AUTO, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0},
        '{1'b1, 1'b1, 1'b0, 12'sd100, 12'sd500, 12'd1,
          1'b0, MODE_AUTO, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 1'b0, 1'b0, 12'sd0, 12'sd0, 12'd0,
          1'b0, MODE_AUTO, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0},
        '{1'b1, 1'b1, 1'b0, -12'sd100, 12'sd500, 12'd0,
          1'b0, MODE_AUTO, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 1'b0, 1'b0, 12'sd0, 12'sd0, 12'd0,
          1'b0, MODE_AUTO, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0},
        '{1'b1, 1'b0, 1'b0, 12'sd0, 12'sd0, 12'd0,
          1'b0, MODE_AUTO, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 1'b0, 1'b0, 12'sd0, 12'sd0, 12'd0,
          1'b0, MODE_AUTO, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0}
    };

    logic                   clk        = 1'b0;
    logic                   rst_n      = 1'b0;
    logic                   cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_idx    = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;
    logic                   tick_valid = 1'b0;
    logic                   tick_ready;
    logic [IN_TDATA_W-1:0]  tick_data  = '0;
    logic                   res_valid;
    logic                   res_ready  = 1'b0;
    logic [OUT_TDATA_W-1:0] res_data;

    // Controller model state.
    t_cfg                      cfg_now;
    logic [1:0]                mode_now;
    logic                      vent_now;
    logic                      lamp_now;
    logic                      btn_prev;
    logic                      buzz_now;
    logic                      fault_now;
    logic signed [FIELD_W-1:0] temp_kept;
    logic [FIELD_W-1:0]        lux_kept;
    logic [FIELD_W-1:0]        press_age;
    logic [FIELD_W-1:0]        beep_age;

    t_result awaited [$];
    int      mismatches    = 0;
    int      run_cycles    = 0;
    bit      calm          = 1'b0;
    bit      hold_off_ask  = 1'b0;
    logic    btn_level     = 1'b1;
    int      btn_run       = 0;

    vent_light_mode_controller_core i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_wdata   (cfg_wdata),
        .s_axis_tvalid (tick_valid),
        .s_axis_tready (tick_ready),
        .s_axis_tdata  (tick_data),
        .m_axis_tvalid (res_valid),
        .m_axis_tready (res_ready),
        .m_axis_tdata  (res_data)
    );

    always begin
        #CLK_HALF_NS clk = 1'b1;
        #CLK_HALF_NS clk = 1'b0;
    end

    function automatic t_result advance_tick(input t_item it);
        int      t_in;
        int      h_in;
        int      t_kept;
        t_result r;
        if (press_age != AGE_SAT) press_age = press_age + 1'b1;
        if (beep_age != AGE_SAT) beep_age = beep_age + 1'b1;
        if (!it.button_level && btn_prev && press_age >= cfg_now.debounce_ticks) begin
            press_age = '0;
            case (mode_now)
                MODE_SAFETY: vent_now = 1'b1;
                MODE_MANUAL: mode_now = MODE_AUTO;
                default: begin
                    mode_now = MODE_MANUAL;
                    vent_now = 1'b1;
                end
            endcase
        end
        btn_prev = it.button_level;
        t_in = $signed(it.temp_tenths);
        h_in = $signed(it.humidity_tenths);
        if (it.sample_valid) begin
            if (it.read_failed || h_in < HUM_MIN_TENTHS || h_in > HUM_MAX_TENTHS ||
                    t_in < TEMP_MIN_TENTHS || t_in > TEMP_MAX_TENTHS) begin
                fault_now = 1'b1;
                mode_now  = MODE_SAFETY;
                vent_now  = 1'b1;
                lamp_now  = 1'b0;
            end else begin
                temp_kept = it.temp_tenths;
                lux_kept  = it.light_reading;
                fault_now = 1'b0;
                if (mode_now == MODE_SAFETY) mode_now = MODE_AUTO;
            end
        end
        if (mode_now == MODE_SAFETY) begin
            vent_now = 1'b1;
            lamp_now = 1'b0;
            if (beep_age >= cfg_now.beep_half_ticks) begin
                beep_age = '0;
                buzz_now = !buzz_now;
            end
        end else begin
            if (mode_now == MODE_MANUAL) begin
                vent_now = 1'b1;
            end else begin
                t_kept = $signed(temp_kept);
                if (t_kept >= $signed(cfg_now.temp_open_tenths)) begin
                    vent_now = 1'b1;
                end else if (t_kept <= $signed(cfg_now.temp_close_tenths)) begin
                    vent_now = 1'b0;
                end
            end
            lamp_now = (lux_kept > cfg_now.lux_limit);
            buzz_now = 1'b0;
        end
        r.mode            = mode_now;
        r.vent_is_opened  = vent_now;
        r.vent_angle      = vent_now ? cfg_now.angle_open : cfg_now.angle_shut;
        r.supplemental_on = lamp_now;
        r.buzzer_on       = buzz_now;
        r.sensor_fault    = fault_now;
        return r;
    endfunction

    function automatic int sender_gap();
        int roll;
        if (calm) return 0;
        roll = $urandom_range(0, 9);
        if (roll < 5) return 0;
        if (roll < 9) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic t_item random_tick();
        t_item it;
        int    lo;
        int    hi;
        int    pick;
        if (btn_run == 0) begin
            btn_level = !btn_level;
            btn_run = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
        end
        btn_run--;
        it.button_level    = btn_level;
        it.sample_valid    = ($urandom_range(0, 2) == 0);
        it.read_failed     = 1'($urandom);
        it.temp_tenths     = 12'($urandom);
        it.humidity_tenths = 12'($urandom);
        it.light_reading   = 12'($urandom);
        if (it.sample_valid && $urandom_range(0, 3) != 0) begin
            it.read_failed     = 1'b0;
            it.humidity_tenths = 12'($urandom_range(0, 1000));
            if ($urandom_range(0, 1) == 0) begin
                lo = $signed(cfg_now.temp_close_tenths) - 20;
                hi = $signed(cfg_now.temp_open_tenths) + 20;
                if (lo > hi) begin
                    pick = lo;
                    lo   = hi;
                    hi   = pick;
                end
                if (lo < TEMP_MIN_TENTHS) lo = TEMP_MIN_TENTHS;
                if (lo > TEMP_MAX_TENTHS) lo = TEMP_MAX_TENTHS;
                if (hi < TEMP_MIN_TENTHS) hi = TEMP_MIN_TENTHS;
                if (hi > TEMP_MAX_TENTHS) hi = TEMP_MAX_TENTHS;
                pick = lo + int'($urandom_range(0, hi - lo));
            end else begin
                pick = TEMP_MIN_TENTHS + int'($urandom_range(0, 1200));
            end
            it.temp_tenths = 12'(pick);
            if ($urandom_range(0, 1) == 0) begin
                pick = int'(cfg_now.lux_limit) + int'($urandom_range(0, 8)) - 4;
                if (pick < 0) pick = 0;
                if (pick > 4095) pick = 4095;
                it.light_reading = 12'(pick);
            end
        end
        return it;
    endfunction

    function automatic t_cfg phase_settings(input int phase);
        t_cfg c;
        int   top;
        if (phase == LOW_PHASE) begin
            c.temp_open_tenths  = 11'h400;
            c.temp_close_tenths = 11'h400;
            c.lux_limit         = 12'd0;
            c.debounce_ticks    = 12'd0;
            c.beep_half_ticks   = 12'd0;
            c.angle_open        = 8'd0;
            c.angle_shut        = 8'd0;
        end else if (phase == HIGH_PHASE) begin
            c.temp_open_tenths  = 11'h3FF;
            c.temp_close_tenths = 11'h3FF;
            c.lux_limit         = 12'hFFF;
            c.debounce_ticks    = 12'hFFF;
            c.beep_half_ticks   = 12'hFFF;
            c.angle_open        = 8'hFF;
            c.angle_shut        = 8'hFF;
        end else begin
            top = int'($urandom_range(0, 1200)) - 400;
            c.temp_open_tenths  = 11'(top);
            c.temp_close_tenths = 11'(top - int'($urandom_range(0, 100)));
            c.lux_limit         = 12'($urandom);
            c.debounce_ticks    = 12'($urandom_range(0, 40));
            c.beep_half_ticks   = 12'($urandom_range(1, 60));
            c.angle_open        = 8'(($urandom_range(0, 9) == 0) ?
                                     $urandom_range(181, 255) : $urandom_range(0, 180));
            c.angle_shut        = 8'(($urandom_range(0, 9) == 0) ?
                                     $urandom_range(181, 255) : $urandom_range(0, 180));
        end
        return c;
    endfunction

    task automatic offer_tick(input t_item it, input logic use_typed, input t_result typed_want);
        int      gap;
        t_result model_out;
        gap = sender_gap();
        if (gap > 0) begin
            tick_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tick_valid <= 1'b1;
        tick_data  <= IN_TDATA_W'(it);
        do @(posedge clk); while (!tick_ready);
        model_out = advance_tick(it);
        awaited.push_back(use_typed ? typed_want : model_out);
    endtask

    task automatic settle();
        tick_valid <= 1'b0;
        while (awaited.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        @(posedge clk);
    endtask

    task automatic load_settings(input t_cfg c);
        write_reg(REG_TEMP_OPEN, 12'($signed(c.temp_open_tenths)));
        write_reg(REG_TEMP_CLOSE, 12'($signed(c.temp_close_tenths)));
        write_reg(REG_LIGHT_THRESH, c.lux_limit);
        write_reg(REG_DEBOUNCE, c.debounce_ticks);
        write_reg(REG_BEEP_HALF, c.beep_half_ticks);
        write_reg(REG_OPEN_ANGLE, 12'(c.angle_open));
        write_reg(REG_CLOSED_ANGLE, 12'(c.angle_shut));
        write_reg(REG_UNUSED, '1);
        cfg_we  <= 1'b0;
        cfg_now = c;
    endtask

    initial begin
        int span;
        forever begin
            if (hold_off_ask) begin
                hold_off_ask = 1'b0;
                res_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end else begin
                if (calm || $urandom_range(0, 3) != 0) begin
                    res_ready <= 1'b1;
                    span = calm ? 1 : $urandom_range(1, 20);
                end else begin
                    res_ready <= 1'b0;
                    span = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) :
                                                         $urandom_range(1, 3);
                end
                repeat (span) @(posedge clk);
            end
        end
    end

    always @(posedge clk) begin
        t_result got;
        t_result want;
        if (rst_n && res_valid && res_ready) begin
            got = res_data[$bits(t_result)-1:0];
            if (awaited.size() == 0) begin
                if (mismatches < REPORT_MAX) begin
                    $display("Unexpected result transaction %h at %0t ns.", got, $time);
                end
                mismatches++;
            end else begin
                want = awaited.pop_front();
                if (got.mode !== want.mode || got.vent_is_opened !== want.vent_is_opened ||
                        got.vent_angle !== want.vent_angle ||
                        got.supplemental_on !== want.supplemental_on ||
                        got.buzzer_on !== want.buzzer_on ||
                        got.sensor_fault !== want.sensor_fault) begin
                    if (mismatches < REPORT_MAX) begin
                        $display("Mismatch at %0t ns (expected/actual): mode %0d/%0d vent %b/%b",
                                 $time, want.mode, got.mode, want.vent_is_opened,
                                 got.vent_is_opened);
                        $display("    angle %0d/%0d light %b/%b buzzer %b/%b fault %b/%b",
                                 want.vent_angle, got.vent_angle, want.supplemental_on,
                                 got.supplemental_on, want.buzzer_on, got.buzzer_on,
                                 want.sensor_fault, got.sensor_fault);
                    end
                    mismatches++;
                end
            end
        end
    end

    initial begin
        while (run_cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            run_cycles++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        t_item   step_item;
        t_result step_want;
        cfg_now   = CFG_RESET;
        mode_now  = MODE_AUTO;
        vent_now  = 1'b0;
        lamp_now  = 1'b0;
        btn_prev  = 1'b1;
        buzz_now  = 1'b0;
        fault_now = 1'b0;
        temp_kept = '0;
        lux_kept  = '0;
        press_age = '0;
        beep_age  = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        for (int n = 0; n < NUM_STEPS; n++) begin
            if (n == PHASE_B_FIRST) begin
                settle();
                load_settings(TABLE_CFG);
            end
            step_item.button_level    = STEPS[n].button;
            step_item.sample_valid    = STEPS[n].sample;
            step_item.read_failed     = STEPS[n].bad_read;
            step_item.temp_tenths     = STEPS[n].temp;
            step_item.humidity_tenths = STEPS[n].hum;
            step_item.light_reading   = STEPS[n].lux;
            step_want.mode            = STEPS[n].mode;
            step_want.vent_is_opened  = STEPS[n].vent;
            step_want.vent_angle      = STEPS[n].angle;
            step_want.supplemental_on = STEPS[n].lamp;
            step_want.buzzer_on       = STEPS[n].buzz;
            step_want.sensor_fault    = STEPS[n].fault;
            offer_tick(step_item, STEPS[n].typed, step_want);
        end

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            settle();
            calm = (p == CALM_PHASE);
            load_settings(phase_settings(p));
            if (p == HIGH_PHASE) begin
                // A failed read enters safety before the random ticks start.
                calm = 1'b1;
                step_item = '0;
                step_item.button_level = 1'b1;
                step_item.sample_valid = 1'b1;
                step_item.read_failed  = 1'b1;
                offer_tick(step_item, 1'b0, '0);
                calm = 1'b0;
            end
            if (p == CALM_PHASE) hold_off_ask = 1'b1;
            repeat (PHASE_TICKS) offer_tick(random_tick(), 1'b0, '0);
        end

        settle();
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
